>>> rtl/utme_pkg.sv
package utme_pkg;

    localparam int MAX_N  = 16;
    localparam int IDX_W  = $clog2(MAX_N);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = MAX_N * MAX_N;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + 8;
    localparam int FRAC_W = 16;
    localparam int SIZE_W = 5;

    localparam logic [1:0] FUNC_WR_A   = 2'd0;
    localparam logic [1:0] FUNC_WR_B   = 2'd1;
    localparam logic [1:0] FUNC_COMP   = 2'd2;
    localparam logic [1:0] FUNC_RD     = 2'd3;

    // operand sources of a multiply-accumulate
    localparam logic [1:0] SRC_ASQ  = 2'd0;  // A * A
    localparam logic [1:0] SRC_BAT  = 2'd1;  // B * A^T
    localparam logic [1:0] SRC_A2B  = 2'd2;  // A2 * B

    typedef struct packed {
        logic               a_we;
        logic               b_we;
        logic [ADDR_W-1:0]  wr_addr;
        logic               mac_valid;
        logic               mac_first;
        logic               mac_last;
        logic [1:0]         src;
        logic [ADDR_W-1:0]  x_addr;
        logic [ADDR_W-1:0]  y_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic               dst_c;
        logic               c_rd_en;
        logic [ADDR_W-1:0]  c_rd_addr;
        logic               sat_clr;
        logic               out_load;
        logic               out_done;
        logic               out_zero;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> rtl/utme_ram.sv
module utme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/utme_ctrl.sv
module utme_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [utme_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_func,
    input  logic [utme_pkg::IDX_W-1:0]      s_row,
    input  logic [utme_pkg::IDX_W-1:0]      s_col,
    output utme_pkg::cmd_t                  cmd,
    input  utme_pkg::status_t               status
);

    localparam int IW = utme_pkg::IDX_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_P1     = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_P2     = 3'd3;
    localparam logic [2:0] ST_DRAIN2 = 3'd4;
    localparam logic [2:0] ST_RESP_C = 3'd5;
    localparam logic [2:0] ST_RESP_R = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [utme_pkg::SIZE_W-1:0] size_reg;
    logic [IW-1:0]               nm1_reg, nm1_next, nm1_cfg;
    logic [IW-1:0]               i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic                        term_reg, term_next;
    logic [1:0]                  drain_reg, drain_next;
    logic                        inside_reg, inside_next;
    logic                        accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        if (size_reg == '0) begin
            nm1_cfg = '0;
        end else if (size_reg > utme_pkg::SIZE_W'(utme_pkg::MAX_N)) begin
            nm1_cfg = IW'(utme_pkg::MAX_N - 1);
        end else begin
            nm1_cfg = IW'(size_reg - 1'b1);
        end
    end

    always_comb begin
        state_next  = state_reg;
        nm1_next    = nm1_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        term_next   = term_reg;
        drain_next  = drain_reg;
        inside_next = inside_reg;
        cmd         = '0;
        cmd.wr_addr   = {s_row, s_col};
        cmd.c_rd_addr = {s_row, s_col};
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        utme_pkg::FUNC_WR_A: cmd.a_we = 1'b1;
                        utme_pkg::FUNC_WR_B: cmd.b_we = 1'b1;
                        utme_pkg::FUNC_COMP: begin
                            cmd.sat_clr = 1'b1;
                            nm1_next    = nm1_cfg;
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            state_next  = ST_P1;
                        end
                        utme_pkg::FUNC_RD: begin
                            cmd.c_rd_en = 1'b1;
                            inside_next = (s_row <= nm1_reg) && (s_col <= nm1_reg);
                            state_next  = ST_RESP_R;
                        end
                    endcase
                end
            end
            ST_P1: begin
                cmd.mac_valid = 1'b1;
                cmd.src       = utme_pkg::SRC_ASQ;
                cmd.x_addr    = {i_reg, k_reg};
                cmd.y_addr    = {k_reg, j_reg};
                cmd.dst_addr  = {i_reg, j_reg};
                cmd.mac_first = (k_reg == i_reg);
                cmd.mac_last  = (k_reg == j_reg);
                if (k_reg == j_reg) begin
                    if (j_reg == nm1_reg) begin
                        if (i_reg == nm1_reg) begin
                            drain_next = '0;
                            state_next = ST_DRAIN1;
                        end else begin
                            i_next = i_reg + 1'b1;
                            j_next = i_reg + 1'b1;
                            k_next = i_reg + 1'b1;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                        k_next = i_reg;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN1: begin
                // let the last A2 writes land before they are read
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    term_next  = 1'b0;
                    state_next = ST_P2;
                end
            end
            ST_P2: begin
                cmd.mac_valid = 1'b1;
                cmd.dst_c     = 1'b1;
                cmd.dst_addr  = {i_reg, j_reg};
                cmd.x_addr    = {i_reg, k_reg};
                cmd.mac_first = !term_reg && (k_reg == j_reg);
                cmd.mac_last  = term_reg && (k_reg == nm1_reg);
                if (term_reg) begin
                    cmd.src    = utme_pkg::SRC_A2B;
                    cmd.y_addr = {k_reg, j_reg};
                end else begin
                    cmd.src    = utme_pkg::SRC_BAT;
                    cmd.y_addr = {j_reg, k_reg};
                end
                if (k_reg == nm1_reg) begin
                    if (!term_reg) begin
                        term_next = 1'b1;
                        k_next    = i_reg;
                    end else if (j_reg == nm1_reg) begin
                        if (i_reg == nm1_reg) begin
                            drain_next = '0;
                            state_next = ST_DRAIN2;
                        end else begin
                            i_next    = i_reg + 1'b1;
                            j_next    = '0;
                            k_next    = '0;
                            term_next = 1'b0;
                        end
                    end else begin
                        j_next    = j_reg + 1'b1;
                        k_next    = j_reg + 1'b1;
                        term_next = 1'b0;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN2: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3) begin
                    state_next = ST_RESP_C;
                end
            end
            ST_RESP_C: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_done = 1'b1;
                    cmd.out_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP_R: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = !inside_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg  <= utme_pkg::SIZE_W'(utme_pkg::MAX_N);
            nm1_reg   <= IW'(utme_pkg::MAX_N - 1);
        end else begin
            state_reg <= state_next;
            nm1_reg   <= nm1_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        term_reg   <= term_next;
        drain_reg  <= drain_next;
        inside_reg <= inside_next;
    end

endmodule

>>> rtl/utme_dp.sv
module utme_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  utme_pkg::cmd_t                  cmd,
    output utme_pkg::status_t               status,
    input  logic [utme_pkg::DATA_W-1:0]     wr_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [utme_pkg::DATA_W-1:0]     out_value,
    output logic                            out_done,
    output logic                            out_sat
);

    localparam int AW = utme_pkg::ADDR_W;
    localparam int DW = utme_pkg::DATA_W;
    localparam int FW = utme_pkg::ACC_W - utme_pkg::FRAC_W;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic [1:0]    src;
        logic          dst_c;
        logic [AW-1:0] dst_addr;
    } tag_t;

    tag_t s1_reg, s2_reg, s3_reg;

    logic [DW-1:0] a0_q, a1_q, b0_q, b1_q, a2_q, c_q;
    logic [AW-1:0] a0_rd_addr;
    logic [DW-1:0] x_d, y_d, fin_value;
    logic signed [utme_pkg::PROD_W-1:0] prod_reg;
    logic signed [utme_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [FW-1:0]               fin;
    logic fin_hi, fin_lo, fin_we;
    logic sat_reg;
    logic out_valid_reg, out_done_reg, out_sat_reg;
    logic [DW-1:0] out_value_reg;

    assign a0_rd_addr = (cmd.src == utme_pkg::SRC_ASQ) ? cmd.x_addr : cmd.y_addr;

    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_a0 (
        .aclk(aclk), .we(cmd.a_we), .wr_addr(cmd.wr_addr), .wr_data(wr_value),
        .rd_en(cmd.mac_valid), .rd_addr(a0_rd_addr), .rd_data(a0_q));
    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_a1 (
        .aclk(aclk), .we(cmd.a_we), .wr_addr(cmd.wr_addr), .wr_data(wr_value),
        .rd_en(cmd.mac_valid), .rd_addr(cmd.y_addr), .rd_data(a1_q));
    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_b0 (
        .aclk(aclk), .we(cmd.b_we), .wr_addr(cmd.wr_addr), .wr_data(wr_value),
        .rd_en(cmd.mac_valid), .rd_addr(cmd.x_addr), .rd_data(b0_q));
    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_b1 (
        .aclk(aclk), .we(cmd.b_we), .wr_addr(cmd.wr_addr), .wr_data(wr_value),
        .rd_en(cmd.mac_valid), .rd_addr(cmd.y_addr), .rd_data(b1_q));
    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_a2 (
        .aclk(aclk), .we(fin_we && !s3_reg.dst_c), .wr_addr(s3_reg.dst_addr),
        .wr_data(fin_value), .rd_en(cmd.mac_valid), .rd_addr(cmd.x_addr),
        .rd_data(a2_q));
    utme_ram #(.WIDTH(DW), .DEPTH(utme_pkg::DEPTH)) u_c (
        .aclk(aclk), .we(fin_we && s3_reg.dst_c), .wr_addr(s3_reg.dst_addr),
        .wr_data(fin_value), .rd_en(cmd.c_rd_en), .rd_addr(cmd.c_rd_addr),
        .rd_data(c_q));

    always_comb begin
        unique case (s1_reg.src)
            utme_pkg::SRC_ASQ: begin
                x_d = a0_q;
                y_d = a1_q;
            end
            utme_pkg::SRC_BAT: begin
                x_d = b0_q;
                y_d = a0_q;
            end
            default: begin
                x_d = a2_q;
                y_d = b1_q;
            end
        endcase
    end

    assign acc_next = (s2_reg.first ? '0 : acc_reg)
                    + utme_pkg::ACC_W'(prod_reg);

    // drop the fraction (floor) and clamp to 32 bits
    assign fin    = acc_reg[utme_pkg::ACC_W-1:utme_pkg::FRAC_W];
    assign fin_hi = !fin[FW-1] && (fin[FW-2:DW-1] != '0);
    assign fin_lo = fin[FW-1] && (fin[FW-2:DW-1] != '1);
    assign fin_we = s3_reg.valid && s3_reg.last;

    always_comb begin
        if (fin_hi) begin
            fin_value = {1'b0, {(DW-1){1'b1}}};
        end else if (fin_lo) begin
            fin_value = {1'b1, {(DW-1){1'b0}}};
        end else begin
            fin_value = fin[DW-1:0];
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            s3_reg.valid  <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_reg.valid <= cmd.mac_valid;
            s2_reg.valid <= s1_reg.valid;
            s3_reg.valid <= s2_reg.valid;
            if (cmd.sat_clr) begin
                sat_reg <= 1'b0;
            end else if (fin_we && (fin_hi || fin_lo)) begin
                sat_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        s1_reg.first    <= cmd.mac_first;
        s1_reg.last     <= cmd.mac_last;
        s1_reg.src      <= cmd.src;
        s1_reg.dst_c    <= cmd.dst_c;
        s1_reg.dst_addr <= cmd.dst_addr;
        s2_reg.first    <= s1_reg.first;
        s2_reg.last     <= s1_reg.last;
        s2_reg.src      <= s1_reg.src;
        s2_reg.dst_c    <= s1_reg.dst_c;
        s2_reg.dst_addr <= s1_reg.dst_addr;
        s3_reg.first    <= s2_reg.first;
        s3_reg.last     <= s2_reg.last;
        s3_reg.src      <= s2_reg.src;
        s3_reg.dst_c    <= s2_reg.dst_c;
        s3_reg.dst_addr <= s2_reg.dst_addr;
        prod_reg <= $signed(x_d) * $signed(y_d);
        if (s2_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load) begin
            out_value_reg <= cmd.out_zero ? '0 : c_q;
            out_done_reg  <= cmd.out_done;
            out_sat_reg   <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_done  = out_done_reg;
    assign out_sat   = out_sat_reg;

endmodule

>>> rtl/upper_triangular_matrix_expression.sv
// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | tdata row,col,element_value; tuser func
// m_      | out | m_tvalid/m_tready | tdata result_value; tuser compute_done,saturated
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data size_n
//
// A read item passes through the C memory read, then the output register. A compute
// runs one MAC per cycle on a single 32x32 multiplier, with a drain after each of
// its two passes.
// Reset is synchronous on aresetn; matrix memories are not cleared.
// A result held by m_tready low stalls the next compute or read response, and all input items behind it.
module upper_triangular_matrix_expression (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // size_n
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // row_index[3:0], col_index[7:4], element_value[39:8]
    input  logic [1:0]  s_tuser,    // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // result_value[31:0]
    output logic [1:0]  m_tuser     // compute_done[0], saturated[1]
);

    utme_pkg::cmd_t    cmd;
    utme_pkg::status_t status;
    logic              out_done, out_sat;

    utme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .s_row    (s_tdata[3:0]),
        .s_col    (s_tdata[7:4]),
        .cmd      (cmd),
        .status   (status)
    );

    utme_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .wr_value (s_tdata[39:8]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_value(m_tdata),
        .out_done (out_done),
        .out_sat  (out_sat)
    );

    assign m_tuser = {out_sat, out_done};

endmodule

>>> tb/tb_top.sv
module tb_top;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } item_t;

    typedef struct {
        logic [31:0] value;
        logic        done;
        logic        sat;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    upper_triangular_matrix_expression uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [31:0] a_mem [utme_pkg::MAX_N*utme_pkg::MAX_N];
    logic [31:0] b_mem [utme_pkg::MAX_N*utme_pkg::MAX_N];
    logic [31:0] asq_mem [utme_pkg::MAX_N*utme_pkg::MAX_N];
    logic [31:0] c_mem [utme_pkg::MAX_N*utme_pkg::MAX_N];
    logic        sat_flag = 1'b0;
    logic [4:0]  dim_reg = 5'd16;

    item_t  pending_items [$];
    reply_t expected_replies [$];
    item_t  offered;
    int     errors = 0;
    int     items_queued = 0;
    int     items_sent = 0;
    int     replies_seen = 0;
    int     computes_sent = 0;
    int     cycle_count = 0;
    int     hold_left = 0;
    bit     hold_done = 0;

    function automatic logic signed [79:0] product(logic [31:0] x, logic [31:0] y);
        logic signed [79:0] sx;
        logic signed [79:0] sy;
        sx = {{48{x[31]}}, x};
        sy = {{48{y[31]}}, y};
        return sx * sy;
    endfunction

    // floor shift of the exact sum, then clamp to 32 bits
    function automatic logic [31:0] round_clamp(logic signed [79:0] acc);
        logic signed [79:0] q;
        q = acc >>> utme_pkg::FRAC_W;
        if (q > 80'sh7FFFFFFF) begin
            sat_flag = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (q < -80'sh80000000) begin
            sat_flag = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function automatic int active_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > utme_pkg::MAX_N) return utme_pkg::MAX_N;
        return dim_reg;
    endfunction

    function automatic void compute_expression();
        int n;
        logic signed [79:0] acc;
        n = active_dim();
        sat_flag = 1'b0;
        for (int i = 0; i < utme_pkg::MAX_N * utme_pkg::MAX_N; i++) begin
            asq_mem[i] = '0;
            c_mem[i] = '0;
        end
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++) begin
                acc = '0;
                for (int k = i; k <= j; k++)
                    acc += product(a_mem[i*utme_pkg::MAX_N+k], a_mem[k*utme_pkg::MAX_N+j]);
                asq_mem[i*utme_pkg::MAX_N+j] = round_clamp(acc);
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                acc = '0;
                for (int k = j; k < n; k++)
                    acc += product(b_mem[i*utme_pkg::MAX_N+k], a_mem[j*utme_pkg::MAX_N+k]);
                for (int k = i; k < n; k++)
                    acc += product(asq_mem[i*utme_pkg::MAX_N+k], b_mem[k*utme_pkg::MAX_N+j]);
                c_mem[i*utme_pkg::MAX_N+j] = round_clamp(acc);
            end
    endfunction

    function automatic void apply_item(item_t it);
        reply_t r;
        case (it.func)
            utme_pkg::FUNC_WR_A: a_mem[it.row*utme_pkg::MAX_N+it.col] = it.value;
            utme_pkg::FUNC_WR_B: b_mem[it.row*utme_pkg::MAX_N+it.col] = it.value;
            utme_pkg::FUNC_COMP: begin
                compute_expression();
                r.value = '0;
                r.done = 1'b1;
                r.sat = sat_flag;
                expected_replies.push_back(r);
            end
            default: begin
                r.value = c_mem[it.row*utme_pkg::MAX_N+it.col];
                r.done = 1'b0;
                r.sat = sat_flag;
                expected_replies.push_back(r);
            end
        endcase
    endfunction

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // no idling on either side while the random traffic passes this span
    function automatic bit quiet_window();
        return items_sent >= 560 && items_sent < 680;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(offered);
                items_sent++;
            end
            // hold the item while it waits for ready
            if (!(s_tvalid && !s_tready)) begin
                if (pending_items.size() > 0 && (quiet_window() || $urandom_range(99) >= 28)) begin
                    item_t nxt;
                    nxt = pending_items.pop_front();
                    offered <= nxt;
                    s_tvalid <= 1'b1;
                    s_tdata <= {nxt.value, nxt.col, nxt.row};
                    s_tuser <= nxt.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result data=%h user=%b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    reply_t e;
                    e = expected_replies.pop_front();
                    if (m_tdata !== e.value || m_tuser[0] !== e.done || m_tuser[1] !== e.sat) begin
                        $display("%0t: mismatch expected value=%h done=%b sat=%b, actual value=%h done=%b sat=%b",
                                 $time, e.value, e.done, e.sat, m_tdata, m_tuser[0], m_tuser[1]);
                        errors++;
                    end
                end
                // stall the output while the sender still has items to offer
                if (replies_seen >= 20 && !hold_done && pending_items.size() > 4) begin
                    hold_done = 1;
                    hold_left = 400;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_window() || $urandom_range(99) >= 28;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) return $urandom;
        if (r < 20) begin
            case ($urandom_range(3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h00000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return 32'($signed($urandom_range(0, (1 << 19) - 1)) - (1 << 18));
    endfunction

    task automatic queue_item(logic [1:0] f, int row, int col, logic [31:0] v);
        item_t it;
        it.func = f;
        it.row = row[3:0];
        it.col = col[3:0];
        it.value = v;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic wait_idle();
        while (items_sent < items_queued || expected_replies.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_size(logic [4:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        dim_reg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int n;
        int r;
        int row;
        int col;
        n = active_dim();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(9) < 8) begin
                row = $urandom_range(n - 1);
                col = $urandom_range(n - 1);
            end else begin
                row = $urandom_range(utme_pkg::MAX_N - 1);
                col = $urandom_range(utme_pkg::MAX_N - 1);
            end
            if (r < 35)      queue_item(utme_pkg::FUNC_WR_A, row, col, rand_value());
            else if (r < 70) queue_item(utme_pkg::FUNC_WR_B, row, col, rand_value());
            else if (r < 75) begin
                queue_item(utme_pkg::FUNC_COMP, row, col, $urandom);
                computes_sent++;
            end
            else             queue_item(utme_pkg::FUNC_RD, row, col, $urandom);
        end
        wait_idle();
    endtask

    logic [4:0] sizes [10] = '{5'd1, 5'd0, 5'd2, 5'd3, 5'd4, 5'd31, 5'd5, 5'd8, 5'd17, 5'd16};

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every element of both matrices so no compute touches an unwritten one
        for (int i = 0; i < utme_pkg::MAX_N; i++)
            for (int j = 0; j < utme_pkg::MAX_N; j++) begin
                queue_item(utme_pkg::FUNC_WR_A, i, j,
                           32'($signed($urandom_range(0, 131071)) - 65536));
                queue_item(utme_pkg::FUNC_WR_B, i, j,
                           32'($signed($urandom_range(0, 131071)) - 65536));
            end
        queue_item(utme_pkg::FUNC_COMP, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 15, 15, 32'hFFFFFFFF);
        queue_item(utme_pkg::FUNC_RD, 0, 15, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 15, 0, 32'd0);
        // drive A to the positive and negative limits and B to the positive limit to force saturation
        queue_item(utme_pkg::FUNC_WR_A, 0, 0, 32'h7FFFFFFF);
        queue_item(utme_pkg::FUNC_WR_B, 0, 0, 32'h7FFFFFFF);
        queue_item(utme_pkg::FUNC_WR_A, 15, 15, 32'h80000000);
        queue_item(utme_pkg::FUNC_WR_A, 15, 0, 32'h7FFFFFFF);
        queue_item(utme_pkg::FUNC_COMP, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 15, 15, 32'd0);
        queue_item(utme_pkg::FUNC_WR_A, 0, 0, 32'h00010000);
        queue_item(utme_pkg::FUNC_WR_B, 0, 0, 32'hFFFF0000);
        queue_item(utme_pkg::FUNC_WR_A, 15, 15, 32'h00008000);
        queue_item(utme_pkg::FUNC_COMP, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 0, 0, 32'd0);
        computes_sent += 3;
        wait_idle();

        // small dimension: entries outside the active region read back as zero
        write_size(5'd2);
        queue_item(utme_pkg::FUNC_COMP, 0, 0, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 1, 1, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 2, 2, 32'd0);
        queue_item(utme_pkg::FUNC_RD, 15, 15, 32'd0);
        computes_sent++;
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            write_size(sizes[p]);
            random_phase(p == 9 ? 27 : 19);
        end
        for (int p = 0; p < 2; p++) begin
            write_size(5'($urandom_range(1, 6)));
            random_phase(10);
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_replies.size());
            errors++;
        end
        $display("Sent %0d items (%0d computes) over sizes 0..31, checked %0d results.",
                 items_sent, computes_sent, replies_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
rtl/utme_pkg.sv
rtl/utme_ram.sv
rtl/utme_ctrl.sv
rtl/utme_dp.sv
rtl/upper_triangular_matrix_expression.sv
tb/tb_top.sv
